// ===== src/kcs_pkg.sv =====
package kcs_pkg;

  localparam int MAX_ELEMENTS = 64;
  localparam int VALUE_WIDTH  = 16;
  localparam int OP_WIDTH     = 2;
  localparam int COUNT_WIDTH  = 7;
  localparam int CNT_W        = $clog2(MAX_ELEMENTS + 1);
  localparam int IDX_W        = $clog2(MAX_ELEMENTS);
  localparam int QUEUE_DEPTH  = 4;
  localparam int QPTR_W       = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OP_WIDTH-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_WIDTH-1:0] OP_APPEND = 2'd1;
  localparam logic [OP_WIDTH-1:0] OP_QUERY  = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_APPEND,
    CMD_QUERY
  } cmd_kind_t;

  // element on append, target on query
  typedef struct packed {
    cmd_kind_t                      kind;
    logic signed [VALUE_WIDTH-1:0]  data;
    logic [COUNT_WIDTH-1:0]         count;
  } cmd_t;

endpackage

// ===== src/kcs_front.sv =====
module kcs_front import kcs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_WIDTH-1:0]           op,
  input  logic signed [VALUE_WIDTH-1:0] element,
  input  logic signed [VALUE_WIDTH-1:0] target,
  input  logic [COUNT_WIDTH-1:0]        count,
  output logic                          cmd_valid,
  input  logic                          cmd_ready,
  output cmd_t                          cmd
);

  cmd_kind_t kind_dec;

  assign in_ready = !cmd_valid || cmd_ready;

  always_comb begin
    case (op)
      OP_CLEAR:  kind_dec = CMD_CLEAR;
      OP_APPEND: kind_dec = CMD_APPEND;
      default:   kind_dec = CMD_QUERY;
    endcase
  end

  // reserved op is taken and dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_valid <= 1'b0;
    end else if (in_ready) begin
      cmd_valid <= in_valid && (op == OP_CLEAR || op == OP_APPEND || op == OP_QUERY);
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      cmd.kind  <= kind_dec;
      cmd.data  <= (op == OP_APPEND) ? element : target;
      cmd.count <= count;
    end
  end

endmodule

// ===== src/kcs_queue.sv =====
module kcs_queue import kcs_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_cmd,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_cmd
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] fill;
  logic              push;
  logic              pop;

  assign push_ready = fill != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = fill != '0;
  assign pop_cmd    = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + QPTR_W'(1);
      if (push && !pop) begin
        fill <= fill + QCNT_W'(1);
      end else if (pop && !push) begin
        fill <= fill - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

endmodule

// ===== src/kcs_back.sv =====
module kcs_back import kcs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cmd_valid,
  output logic                          cmd_ready,
  input  cmd_t                          cmd,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          last,
  output logic                          error
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_ERR,
    S_FIRST,
    S_LAST,
    S_BS,
    S_BS_WAIT,
    S_WIN,
    S_RDL,
    S_RDR,
    S_CMP,
    S_EMIT_RD,
    S_EMIT_WAIT
  } state_t;

  state_t                        state;
  logic signed [VALUE_WIDTH-1:0] mem [MAX_ELEMENTS];
  logic signed [VALUE_WIDTH-1:0] rd_data;
  logic signed [VALUE_WIDTH-1:0] x;
  logic signed [VALUE_WIDTH-1:0] lv;
  logic [IDX_W-1:0]              rd_addr;
  logic [CNT_W-1:0]              n;
  logic [CNT_W-1:0]              kk;
  logic [CNT_W-1:0]              lo;
  logic [CNT_W-1:0]              hi;
  logic [CNT_W-1:0]              left;
  logic [CNT_W-1:0]              right;
  logic [CNT_W-1:0]              taken;
  logic [CNT_W-1:0]              ptr;
  logic [CNT_W-1:0]              rem;
  logic [CNT_W-1:0]              nm1;
  logic [CNT_W-1:0]              lm1;
  logic [CNT_W:0]                mid_sum;
  logic [CNT_W-1:0]              mid;
  logic                          pop;
  logic                          bad_k;
  logic                          mem_we;
  logic                          out_free;
  logic                          emit;
  logic                          go_left;

  function automatic logic [VALUE_WIDTH:0] abs_diff(
    input logic signed [VALUE_WIDTH-1:0] a,
    input logic signed [VALUE_WIDTH-1:0] b
  );
    logic signed [VALUE_WIDTH:0] d;
    logic [VALUE_WIDTH:0]        u;
    d = {a[VALUE_WIDTH-1], a} - {b[VALUE_WIDTH-1], b};
    u = d;
    abs_diff = d[VALUE_WIDTH] ? (~u + (VALUE_WIDTH + 1)'(1)) : u;
  endfunction

  assign cmd_ready = state == S_IDLE;
  assign pop       = cmd_valid && cmd_ready;
  assign bad_k     = cmd.count == '0 || int'(cmd.count) > int'(n);
  assign mem_we    = pop && cmd.kind == CMD_APPEND && n < CNT_W'(MAX_ELEMENTS);
  assign out_free  = !out_valid || out_ready;
  assign emit      = out_free && (state == S_ERR || state == S_EMIT_WAIT);
  assign nm1       = n - CNT_W'(1);
  assign lm1       = left - CNT_W'(1);
  assign mid_sum   = {1'b0, lo} + {1'b0, hi};
  assign mid       = mid_sum[CNT_W:1];

  // equal distances favor the left neighbor
  always_comb begin
    if (left != '0 && right < n) begin
      go_left = abs_diff(lv, x) <= abs_diff(rd_data, x);
    end else begin
      go_left = left != '0;
    end
  end

  always_comb begin
    case (state)
      S_FIRST:     rd_addr = nm1[IDX_W-1:0];
      S_BS:        rd_addr = mid[IDX_W-1:0];
      S_BS_WAIT:   rd_addr = mid[IDX_W-1:0];
      S_RDL:       rd_addr = lm1[IDX_W-1:0];
      S_RDR:       rd_addr = right[IDX_W-1:0];
      S_EMIT_RD:   rd_addr = ptr[IDX_W-1:0];
      S_EMIT_WAIT: rd_addr = ptr[IDX_W-1:0];
      default:     rd_addr = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[n[IDX_W-1:0]] <= cmd.data;
    rd_data <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      n         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready && !emit) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (pop) begin
            case (cmd.kind)
              CMD_CLEAR: n <= '0;
              CMD_APPEND: begin
                if (mem_we) n <= n + CNT_W'(1);
              end
              CMD_QUERY: begin
                x  <= cmd.data;
                kk <= CNT_W'(cmd.count);
                state <= bad_k ? S_ERR : S_FIRST;
              end
              default: ;
            endcase
          end
        end
        S_ERR: begin
          if (out_free) begin
            out_valid <= 1'b1;
            value     <= '0;
            last      <= 1'b1;
            error     <= 1'b1;
            state     <= S_IDLE;
          end
        end
        S_FIRST: begin
          if (x < rd_data) begin
            ptr   <= '0;
            rem   <= kk;
            state <= S_EMIT_RD;
          end else begin
            state <= S_LAST;
          end
        end
        S_LAST: begin
          if (x > rd_data) begin
            ptr   <= n - kk;
            rem   <= kk;
            state <= S_EMIT_RD;
          end else begin
            lo    <= '0;
            hi    <= n;
            state <= S_BS;
          end
        end
        S_BS: begin
          if (lo < hi) begin
            state <= S_BS_WAIT;
          end else begin
            left  <= lo;
            right <= lo;
            taken <= '0;
            state <= S_WIN;
          end
        end
        S_BS_WAIT: begin
          if (rd_data < x) begin
            lo <= mid + CNT_W'(1);
          end else begin
            hi <= mid;
          end
          state <= S_BS;
        end
        S_WIN: begin
          if (taken == kk) begin
            ptr   <= left;
            rem   <= kk;
            state <= S_EMIT_RD;
          end else begin
            state <= S_RDL;
          end
        end
        S_RDL: state <= S_RDR;
        S_RDR: begin
          lv    <= rd_data;
          state <= S_CMP;
        end
        S_CMP: begin
          if (go_left) begin
            left <= lm1;
          end else begin
            right <= right + CNT_W'(1);
          end
          taken <= taken + CNT_W'(1);
          state <= S_WIN;
        end
        S_EMIT_RD: state <= S_EMIT_WAIT;
        S_EMIT_WAIT: begin
          if (out_free) begin
            out_valid <= 1'b1;
            value     <= rd_data;
            last      <= rem == CNT_W'(1);
            error     <= 1'b0;
            if (rem == CNT_W'(1)) begin
              state <= S_IDLE;
            end else begin
              ptr   <= ptr + CNT_W'(1);
              rem   <= rem - CNT_W'(1);
              state <= S_EMIT_RD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== src/k_closest_in_sorted_array.sv =====
// k closest elements of an ascending store
// input channel (in_valid/in_ready): one beat carries op, element, target, count.
//   op 0 clears the store, op 1 appends element, op 2 queries target with k = count,
//   op 3 is taken and dropped.
// output channel (out_valid/out_ready): one beat per result: value, last, error.
//   a query gives k beats ascending, last on the final one; k of zero or above
//   the stored count gives one beat with error and last set and value zero.
// input beats pass an input register and a four-entry command queue to the
//   executing engine; clears and appends retire one per cycle while the engine is
//   idle, so they are taken every cycle while the queue has room.
// query steps in the engine: the end checks, then binary search steps (up to 7
//   steps at 64 entries), then window steps (k steps), then one store read per
//   result beat; the single read port of the store shapes these steps. input
//   beats keep queueing behind a running query.
// when the receiver stalls, the current result beat holds in the output register
//   and the engine waits; the queue then fills and in_ready drops.
// reset empties the store count, the queue and the output register; store
//   contents are undefined until written.
module k_closest_in_sorted_array import kcs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [OP_WIDTH-1:0]           op,
  input  logic signed [VALUE_WIDTH-1:0] element,
  input  logic signed [VALUE_WIDTH-1:0] target,
  input  logic [COUNT_WIDTH-1:0]        count,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [VALUE_WIDTH-1:0] value,
  output logic                          last,
  output logic                          error
);

  logic f_valid;
  logic f_ready;
  cmd_t f_cmd;
  logic q_valid;
  logic q_ready;
  cmd_t q_cmd;

  kcs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .element   (element),
    .target    (target),
    .count     (count),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  kcs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_ready (f_ready),
    .push_cmd   (f_cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_cmd    (q_cmd)
  );

  kcs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (q_valid),
    .cmd_ready (q_ready),
    .cmd       (q_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .last      (last),
    .error     (error)
  );

  a_err_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> last)
    else $error("error beat without last");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> value == '0)
    else $error("error beat with nonzero value");

  a_rst_idle: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid right after reset");

endmodule

// ===== verif/kcs_checker.sv =====
`timescale 1ns / 100ps

module kcs_checker import kcs_pkg::*; (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_ready,
  input  logic [OP_WIDTH-1:0]           op,
  input  logic signed [VALUE_WIDTH-1:0] element,
  input  logic signed [VALUE_WIDTH-1:0] target,
  input  logic [COUNT_WIDTH-1:0]        count,
  input  logic                          out_valid,
  input  logic                          out_ready,
  input  logic signed [VALUE_WIDTH-1:0] value,
  input  logic                          last,
  input  logic                          error,
  output int                            mismatches,
  output int                            pending,
  output int                            beats_in,
  output int                            queries,
  output int                            rejects,
  output int                            beats_out
);

  typedef struct packed {
    logic signed [VALUE_WIDTH-1:0] value;
    logic                          last;
    logic                          error;
  } result_t;

  result_t                       closest_q[$];
  logic signed [VALUE_WIDTH-1:0] store_mem [MAX_ELEMENTS];
  int                            fill;

  function automatic longint abs_diff(longint a, longint b);
    return (a >= b) ? a - b : b - a;
  endfunction

  function automatic int first_not_below(longint x);
    int lo, hi, mid;
    lo = 0;
    hi = fill;
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (store_mem[mid] < x) lo = mid + 1;
      else hi = mid;
    end
    return lo;
  endfunction

  // queue up the k nearest entries around x, ascending, or one error beat for a bad k
  function automatic void pick_closest(longint x, int k);
    int      first, lft, rgt, p;
    result_t r;
    if (k == 0 || k > fill) begin
      r.value = '0;
      r.last  = 1'b1;
      r.error = 1'b1;
      closest_q.insert(closest_q.size(), r);
      rejects++;
      return;
    end
    if (x < store_mem[0]) begin
      first = 0;
    end else if (x > store_mem[fill-1]) begin
      first = fill - k;
    end else begin
      lft = first_not_below(x);
      rgt = lft;
      repeat (k) begin
        if (lft > 0 && rgt < fill) begin
          // ties go to the left neighbor
          if (abs_diff(store_mem[lft-1], x) <= abs_diff(store_mem[rgt], x)) lft--;
          else rgt++;
        end else if (lft > 0) begin
          lft--;
        end else begin
          rgt++;
        end
      end
      first = lft;
    end
    for (p = 0; p < k; p++) begin
      r.value = store_mem[first+p];
      r.last  = (p == k - 1);
      r.error = 1'b0;
      closest_q.insert(closest_q.size(), r);
    end
  endfunction

  always @(posedge clk) begin : monitor
    result_t got, want;
    if (rst) begin
      fill       = 0;
      mismatches = 0;
      beats_in   = 0;
      queries    = 0;
      rejects    = 0;
      beats_out  = 0;
      closest_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        beats_in++;
        case (op)
          OP_CLEAR: fill = 0;
          OP_APPEND: begin
            if (fill < MAX_ELEMENTS) begin
              store_mem[fill] = element;
              fill++;
            end
          end
          OP_QUERY: begin
            queries++;
            pick_closest(target, count);
          end
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        beats_out++;
        got.value = value;
        got.last  = last;
        got.error = error;
        if (closest_q.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected result beat %0d: value %0d last %0b error %0b",
                     beats_out, $signed(got.value), got.last, got.error);
          mismatches++;
        end else begin
          want = closest_q.pop_front();
          if (got.value !== want.value || got.last !== want.last ||
              got.error !== want.error) begin
            if (mismatches < 10) begin
              $display("result beat %0d: expected value %0d last %0b error %0b",
                       beats_out, $signed(want.value), want.last, want.error);
              $display("  got value %0d last %0b error %0b",
                       $signed(got.value), got.last, got.error);
            end
            mismatches++;
          end
        end
      end
    end
    pending = closest_q.size();
  end

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import kcs_pkg::*;

  localparam logic [OP_WIDTH-1:0] OP_RESERVED = 2'd3;
  localparam int ITEM_GOAL   = 160;
  localparam int CYCLE_LIMIT = 600000;
  localparam int DRAIN_WAIT  = 400;

  logic                          clk;
  logic                          rst;
  logic                          in_valid;
  logic                          in_ready;
  logic [OP_WIDTH-1:0]           op;
  logic signed [VALUE_WIDTH-1:0] element;
  logic signed [VALUE_WIDTH-1:0] target;
  logic [COUNT_WIDTH-1:0]        count;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  logic signed [VALUE_WIDTH-1:0] value;
  logic                          last;
  logic                          error;

  int mismatches, pending, beats_in, queries, rejects, beats_out;
  int items_sent = 0;
  int burst_left = 0;
  bit steady     = 1'b0;
  int held[$];
  int cycles;
  int rx_mode    = 0;
  int rx_left    = 0;

  k_closest_in_sorted_array dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .op        (op),
    .element   (element),
    .target    (target),
    .count     (count),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .value     (value),
    .last      (last),
    .error     (error)
  );

  kcs_checker chk (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .op         (op),
    .element    (element),
    .target     (target),
    .count      (count),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .value      (value),
    .last       (last),
    .error      (error),
    .mismatches (mismatches),
    .pending    (pending),
    .beats_in   (beats_in),
    .queries    (queries),
    .rejects    (rejects),
    .beats_out  (beats_out)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Verification failed");
    $finish;
  end

  // receiver stall pattern: phases of always ready, coin flip, and long stalls
  always @(negedge clk) begin
    if (rx_left == 0) begin
      rx_mode = $urandom_range(0, 2);
      rx_left = $urandom_range(20, 200);
    end
    rx_left--;
    case (rx_mode)
      0: out_ready = 1'b1;
      1: out_ready = ($urandom_range(0, 1) == 1);
      default: out_ready = ($urandom_range(0, 5) == 0);
    endcase
  end

  task automatic send_beat(input logic [OP_WIDTH-1:0] o, input int e, input int t,
                           input int k);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    op       = o;
    element  = e[VALUE_WIDTH-1:0];
    target   = t[VALUE_WIDTH-1:0];
    count    = k[COUNT_WIDTH-1:0];
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (o != OP_RESERVED && !(o == OP_APPEND && held.size() >= MAX_ELEMENTS))
      items_sent++;
    case (o)
      OP_CLEAR: held.delete();
      OP_APPEND: begin
        if (held.size() < MAX_ELEMENTS) held.insert(held.size(), int'(element));
      end
      default: ;
    endcase
    if (!steady) begin
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 10);
        gap = $urandom_range(1, 6);
        @(negedge clk);
        in_valid = 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
  endtask

  task automatic clear_store();
    send_beat(OP_CLEAR, $urandom_range(0, 65535), $urandom_range(0, 65535),
              $urandom_range(0, 64));
  endtask

  task automatic append(input int v);
    send_beat(OP_APPEND, v, $urandom_range(0, 65535), $urandom_range(0, 64));
  endtask

  task automatic query(input int t, input int k);
    send_beat(OP_QUERY, $urandom_range(0, 65535), t, k);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
  endtask

  task automatic fill_sorted(input int n);
    int cur, cap, room, i;
    case ($urandom_range(0, 2))
      0: cap = 3;
      1: cap = 300;
      default: cap = 131072 / (n + 1);
    endcase
    if (cap > 300) begin
      cur = $urandom_range(0, cap);
      cur -= 32768;
    end else begin
      cur = $urandom_range(0, 65535);
      cur -= 32768;
    end
    for (i = 0; i < n; i++) begin
      append(cur);
      room = 32767 - cur;
      cur += $urandom_range(0, (room < cap) ? room : cap);
    end
  endtask

  function automatic int pick_target();
    int n, i, t;
    n = held.size();
    t = $urandom_range(0, 65535);
    t -= 32768;
    if (n == 0) return t;
    i = $urandom_range(0, n - 1);
    case ($urandom_range(0, 19))
      0, 1, 2, 3, 4, 5, 6, 7: t = held[i];
      8, 9, 10, 11: begin
        if (held[i] == 32767 || ($urandom_range(0, 1) && held[i] > -32768)) t = held[i] - 1;
        else t = held[i] + 1;
      end
      12, 13: begin
        if (held[0] > -32768) begin
          t = $urandom_range(0, held[0] + 32767);
          t -= 32768;
        end
      end
      14, 15: begin
        if (held[n-1] < 32767) t = held[n-1] + 1 + $urandom_range(0, 32766 - held[n-1]);
      end
      default: ;
    endcase
    return t;
  endfunction

  function automatic int pick_count();
    int n, r;
    n = held.size();
    r = $urandom_range(0, 19);
    if (n == 0) return $urandom_range(0, 64);
    if (r == 0) return 0;
    if (r <= 2 && n < MAX_ELEMENTS) return $urandom_range(n + 1, 64);
    return $urandom_range(1, n);
  endfunction

  initial begin
    int seq, kind;
    rst      = 1'b1;
    in_valid = 1'b0;
    op       = OP_CLEAR;
    element  = '0;
    target   = '0;
    count    = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // empty store, reserved op, extremes and ties
    query(0, 1);
    query(0, 0);
    send_beat(OP_RESERVED, 1234, -1234, 5);
    append(-32768);
    append(-5);
    append(0);
    append(7);
    append(7);
    append(32767);
    query(-32768, 6);
    query(32767, 1);
    query(3, 2);
    query(7, 2);
    query(-32768, 7);
    query(100, 0);
    clear_store();
    append(10);
    append(20);
    append(30);
    query(-32768, 2);
    query(32767, 3);
    query(15, 1);
    query(20, 64);
    drain();

    seq = 0;
    while (items_sent < ITEM_GOAL) begin
      steady = ($urandom_range(0, 4) == 0);
      kind = (seq == 0) ? 0 : $urandom_range(0, 9);
      if (kind < 8) begin
        clear_store();
        if (seq == 0) fill_sorted(MAX_ELEMENTS + 2);
        else if ($urandom_range(0, 11) == 0) fill_sorted(MAX_ELEMENTS);
        else fill_sorted($urandom_range(1, 12));
        repeat ($urandom_range(1, 6)) begin
          query(pick_target(), pick_count());
          if ($urandom_range(0, 9) == 0)
            send_beat(OP_RESERVED, $urandom_range(0, 65535), $urandom_range(0, 65535),
                      $urandom_range(0, 64));
        end
      end else if (kind == 8) begin
        repeat ($urandom_range(1, 6))
          send_beat(OP_WIDTH'($urandom_range(0, 3)), $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 64));
      end else begin
        // unsorted appends on top of whatever is held
        repeat ($urandom_range(1, 8)) append($urandom_range(0, 65535));
        repeat ($urandom_range(1, 3)) query(pick_target(), pick_count());
      end
      if ($urandom_range(0, 3) == 0) drain();
      seq++;
    end
    steady = 1'b1;

    @(negedge clk);
    in_valid = 1'b0;
    wait (pending == 0);
    repeat (DRAIN_WAIT) @(posedge clk);

    $display("covered %0d input beats in %0d sequences: %0d queries, %0d rejected",
             beats_in, seq, queries, rejects);
    $display("checked %0d result beats under random sender gaps and receiver stalls",
             beats_out);
    if (mismatches == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
